/* src/bmma_pkg.sv */
// shared types and constants for the block matrix multiply-accumulate
`default_nettype none
package bmma_pkg;

  // request kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_MAC   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC_ISSUE,
    ST_MAC_WAIT,
    ST_MAC_WB,
    ST_RD_ISSUE,
    ST_RD_LOAD
  } ctrl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic ab_wr;      // write input pair into a and b stores
    logic c_clear;    // invalidate every c entry
    logic ab_rd;      // read one a and one b operand
    logic mac_last;   // operand pair is the last term of the dot product
    logic acc_clear;  // zero the dot product accumulator
    logic c_rd;       // read one c entry
    logic c_rd_seq;   // c read address comes from the read-out counter
    logic c_wr;       // write accumulated sum back to c
    logic out_load;   // load the output register
    logic out_last;   // loaded element ends the read-out run
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic acc_done;   // last product of a dot product has been added
    logic out_free;   // output register can take a new element
  } dp_sts_t;

  // register map
  localparam logic REG_BLOCK_SIZE = 1'b0;
  localparam logic [3:0] BLOCK_SIZE_RESET = 4'd8;

  // field widths
  localparam int IDX_W  = 6;
  localparam int WORD_W = 32;

endpackage
`default_nettype wire

/* src/bmma_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none
module bmma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* src/bmma_ctrl.sv */
// sequencer for load, multiply-accumulate, read-out and clear requests
`default_nettype none
module bmma_ctrl #(
  parameter int MAX_BLOCK = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [$clog2(MAX_BLOCK+1)-1:0] n_act,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire bmma_pkg::op_t             in_op,
  input  wire bmma_pkg::dp_sts_t         sts,
  output bmma_pkg::dp_cmd_t              cmd,
  output logic [$clog2(MAX_BLOCK+1)-1:0] row,
  output logic [$clog2(MAX_BLOCK+1)-1:0] col,
  output logic [$clog2(MAX_BLOCK+1)-1:0] k,
  output logic [((MAX_BLOCK > 1) ? $clog2(MAX_BLOCK*MAX_BLOCK) : 1)-1:0] item
);

  localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int PROD_W = 2 * CNT_W;
  localparam int ITEM_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK * MAX_BLOCK) : 1;

  bmma_pkg::ctrl_state_t state, state_next;

  logic               accept;
  logic [CNT_W-1:0]   n_m1;
  logic [PROD_W-1:0]  total;
  logic               k_end;
  logic               col_end;
  logic               row_end;
  logic               item_end;

  assign accept   = in_valid && in_ready;
  assign n_m1     = n_act - CNT_W'(1);
  assign total    = PROD_W'(n_act) * PROD_W'(n_act);
  assign k_end    = (k == n_m1);
  assign col_end  = (col == n_m1);
  assign row_end  = (row == n_m1);
  assign item_end = ((PROD_W'(item) + PROD_W'(1)) == total);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bmma_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            bmma_pkg::OP_MAC:  state_next = bmma_pkg::ST_MAC_ISSUE;
            bmma_pkg::OP_READ: state_next = bmma_pkg::ST_RD_ISSUE;
            bmma_pkg::OP_LOAD,
            bmma_pkg::OP_CLEAR: state_next = bmma_pkg::ST_IDLE;
          endcase
        end
      end
      bmma_pkg::ST_MAC_ISSUE: begin
        if (k_end) state_next = bmma_pkg::ST_MAC_WAIT;
      end
      bmma_pkg::ST_MAC_WAIT: begin
        if (sts.acc_done) state_next = bmma_pkg::ST_MAC_WB;
      end
      bmma_pkg::ST_MAC_WB: begin
        state_next = (col_end && row_end) ? bmma_pkg::ST_IDLE : bmma_pkg::ST_MAC_ISSUE;
      end
      bmma_pkg::ST_RD_ISSUE: begin
        state_next = bmma_pkg::ST_RD_LOAD;
      end
      bmma_pkg::ST_RD_LOAD: begin
        if (sts.out_free) begin
          state_next = item_end ? bmma_pkg::ST_IDLE : bmma_pkg::ST_RD_ISSUE;
        end
      end
      default: state_next = bmma_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      bmma_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.acc_clear = 1'b1;
        cmd.ab_wr     = in_valid && (in_op == bmma_pkg::OP_LOAD);
        cmd.c_clear   = in_valid && (in_op == bmma_pkg::OP_CLEAR);
      end
      bmma_pkg::ST_MAC_ISSUE: begin
        cmd.ab_rd    = 1'b1;
        cmd.mac_last = k_end;
        // fetch the old c entry alongside the first term
        cmd.c_rd     = (k == '0);
      end
      bmma_pkg::ST_MAC_WAIT: begin
        cmd = '0;
      end
      bmma_pkg::ST_MAC_WB: begin
        cmd.c_wr      = 1'b1;
        cmd.acc_clear = 1'b1;
      end
      bmma_pkg::ST_RD_ISSUE: begin
        cmd.c_rd     = 1'b1;
        cmd.c_rd_seq = 1'b1;
      end
      bmma_pkg::ST_RD_LOAD: begin
        cmd.out_load = sts.out_free;
        cmd.out_last = item_end;
      end
      default: cmd = '0;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bmma_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // loop counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row  <= '0;
      col  <= '0;
      k    <= '0;
      item <= '0;
    end else begin
      case (state)
        bmma_pkg::ST_IDLE: begin
          row  <= '0;
          col  <= '0;
          k    <= '0;
          item <= '0;
        end
        bmma_pkg::ST_MAC_ISSUE: begin
          k <= k_end ? '0 : k + CNT_W'(1);
        end
        bmma_pkg::ST_MAC_WB: begin
          if (col_end) begin
            col <= '0;
            row <= row + CNT_W'(1);
          end else begin
            col <= col + CNT_W'(1);
          end
        end
        bmma_pkg::ST_RD_LOAD: begin
          if (sts.out_free && !item_end) begin
            item <= item + ITEM_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* src/bmma_dp.sv */
// operand stores, shared multiply-accumulate unit, c store and output register
`default_nettype none
module bmma_dp #(
  parameter int MAX_BLOCK = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [$clog2(MAX_BLOCK+1)-1:0] n_act,
  input  wire bmma_pkg::dp_cmd_t         cmd,
  output bmma_pkg::dp_sts_t              sts,
  input  wire logic [$clog2(MAX_BLOCK+1)-1:0] row,
  input  wire logic [$clog2(MAX_BLOCK+1)-1:0] col,
  input  wire logic [$clog2(MAX_BLOCK+1)-1:0] k,
  input  wire logic [((MAX_BLOCK > 1) ? $clog2(MAX_BLOCK*MAX_BLOCK) : 1)-1:0] item,
  input  wire logic [bmma_pkg::IDX_W-1:0]  in_index,
  input  wire logic [bmma_pkg::WORD_W-1:0] in_a,
  input  wire logic [bmma_pkg::WORD_W-1:0] in_b,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [bmma_pkg::WORD_W-1:0]    out_elem,
  output logic [bmma_pkg::IDX_W-1:0]     out_index,
  output logic                           out_last
);

  localparam int DEPTH  = MAX_BLOCK * MAX_BLOCK;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int PROD_W = 2 * CNT_W;
  localparam int W      = bmma_pkg::WORD_W;

  logic              load_ok;
  logic [ADDR_W-1:0] ld_addr;
  logic [ADDR_W-1:0] a_addr;
  logic [ADDR_W-1:0] b_addr;
  logic [ADDR_W-1:0] c_mac_addr;
  logic [ADDR_W-1:0] c_raddr;
  logic [W-1:0]      a_rdata;
  logic [W-1:0]      b_rdata;
  logic [W-1:0]      c_rdata;
  logic [W-1:0]      c_old;
  logic [DEPTH-1:0]  c_valid;
  logic              c_rd_valid;
  logic              v1;
  logic              l1;
  logic              v2;
  logic              l2;
  logic [W-1:0]      prod;
  logic [W-1:0]      acc;
  logic              done;

  // load address, out-of-range positions are dropped
  assign load_ok = ({1'b0, in_index} < (bmma_pkg::IDX_W + 1)'(DEPTH));
  assign ld_addr = ADDR_W'(in_index);

  // operand and result addresses, row-major with the active size
  assign a_addr     = ADDR_W'(PROD_W'(n_act) * PROD_W'(row) + PROD_W'(k));
  assign b_addr     = ADDR_W'(PROD_W'(n_act) * PROD_W'(k) + PROD_W'(col));
  assign c_mac_addr = ADDR_W'(PROD_W'(n_act) * PROD_W'(row) + PROD_W'(col));
  assign c_raddr    = cmd.c_rd_seq ? ADDR_W'(item) : c_mac_addr;

  bmma_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_a_ram (
    .clk   (clk),
    .we    (cmd.ab_wr && load_ok),
    .waddr (ld_addr),
    .wdata (in_a),
    .re    (cmd.ab_rd),
    .raddr (a_addr),
    .rdata (a_rdata)
  );

  bmma_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_b_ram (
    .clk   (clk),
    .we    (cmd.ab_wr && load_ok),
    .waddr (ld_addr),
    .wdata (in_b),
    .re    (cmd.ab_rd),
    .raddr (b_addr),
    .rdata (b_rdata)
  );

  bmma_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_c_ram (
    .clk   (clk),
    .we    (cmd.c_wr),
    .waddr (c_mac_addr),
    .wdata (c_old + acc),
    .re    (cmd.c_rd),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // c entries never written since reset or clear read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid    <= '0;
      c_rd_valid <= 1'b0;
    end else begin
      if (cmd.c_clear) begin
        c_valid <= '0;
      end else if (cmd.c_wr) begin
        c_valid[c_mac_addr] <= 1'b1;
      end
      if (cmd.c_rd) begin
        c_rd_valid <= c_valid[c_raddr];
      end
    end
  end

  assign c_old = c_rd_valid ? c_rdata : '0;

  // mac pipeline control: ram read, product, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      l1   <= 1'b0;
      v2   <= 1'b0;
      l2   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= cmd.ab_rd;
      l1   <= cmd.ab_rd && cmd.mac_last;
      v2   <= v1;
      l2   <= l1;
      done <= v2 && l2;
    end
  end

  // product and accumulator, both wrap to 32 bits
  always_ff @(posedge clk) begin
    prod <= a_rdata * b_rdata;
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + prod;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_elem  <= c_old;
      out_index <= bmma_pkg::IDX_W'(item);
      out_last  <= cmd.out_last;
    end
  end

  assign sts.acc_done = done;
  assign sts.out_free = !out_valid || out_ready;

endmodule
`default_nettype wire

/* src/block_matrix_multiply_accumulate.sv */
// top level of the block matrix multiply-accumulate kernel
// Computes C += A*B on square signed 32-bit blocks of n x n, n set by the
// block_size register (0 acts as 1, above MAX_BLOCK acts as MAX_BLOCK).
// Requests arrive on the s_ stream: tuser holds the kind (load, multiply,
// read, clear), tdata the load position and the A and B elements.
// A load or clear request is taken in idle, which it does not leave. A multiply
// runs every dot product through one shared multiply-accumulate unit: it
// issues the terms, drains the product pipeline (operand read, product,
// accumulate) and then writes C back. A read request streams the n*n C
// elements on the m_ stream in row-major order, tlast on the final one;
// each element is read from C and loaded before the next read is issued.
// One request is worked on at a time; s_tready is high only between them.
// A stalled m_ side holds the pending element in the output register and
// pauses the read-out; a new request may be taken while the last element
// of a run still waits.
// Reset clears C (through per-entry valid bits) and sets block_size to 8;
// A and B hold no value until loaded. Configuration must be written over the
// APB port only while the block is idle; the block itself does not enforce this.
`default_nettype none
module block_matrix_multiply_accumulate #(
  parameter int MAX_BLOCK = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [71:0] s_tdata,   // elem_index[5:0], a_elem[37:6], b_elem[69:38], zero pad
  input  wire logic [1:0]  s_tuser,   // cmd[1:0]
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // c_elem[31:0], c_index[37:32], zero pad
  output logic             m_tlast,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int CNT_W  = $clog2(MAX_BLOCK + 1);
  localparam int DEPTH  = MAX_BLOCK * MAX_BLOCK;
  localparam int ITEM_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IDX_W  = bmma_pkg::IDX_W;
  localparam int W      = bmma_pkg::WORD_W;

  logic [3:0]         block_size;
  logic [CNT_W-1:0]   n_act;
  bmma_pkg::dp_cmd_t  dp_cmd;
  bmma_pkg::dp_sts_t  dp_sts;
  logic [CNT_W-1:0]   row;
  logic [CNT_W-1:0]   col;
  logic [CNT_W-1:0]   k;
  logic [ITEM_W-1:0]  item;
  logic [W-1:0]       out_elem;
  logic [IDX_W-1:0]   out_index;
  logic               cfg_wr;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == bmma_pkg::REG_BLOCK_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= bmma_pkg::BLOCK_SIZE_RESET;
    end else if (cfg_wr) begin
      block_size <= pwdata[3:0];
    end
  end

  assign prdata = (paddr[2] == bmma_pkg::REG_BLOCK_SIZE) ? {28'd0, block_size} : 32'd0;

  // active block size, clamped to 1..MAX_BLOCK
  always_comb begin
    if (block_size == 4'd0) begin
      n_act = CNT_W'(1);
    end else if (block_size > 4'(MAX_BLOCK)) begin
      n_act = CNT_W'(MAX_BLOCK);
    end else begin
      n_act = CNT_W'(block_size);
    end
  end

  bmma_ctrl #(.MAX_BLOCK(MAX_BLOCK)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .n_act    (n_act),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (bmma_pkg::op_t'(s_tuser)),
    .sts      (dp_sts),
    .cmd      (dp_cmd),
    .row      (row),
    .col      (col),
    .k        (k),
    .item     (item)
  );

  bmma_dp #(.MAX_BLOCK(MAX_BLOCK)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .n_act     (n_act),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .row       (row),
    .col       (col),
    .k         (k),
    .item      (item),
    .in_index  (s_tdata[5:0]),
    .in_a      (s_tdata[37:6]),
    .in_b      (s_tdata[69:38]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_elem  (out_elem),
    .out_index (out_index),
    .out_last  (m_tlast)
  );

  assign m_tdata = {2'b00, out_index, out_elem};

  // no write-back and clear of c in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    !(dp_cmd.c_wr && dp_cmd.c_clear))
    else $error("c write-back collides with clear");

  // output register is only loaded when its element has left
  assert property (@(posedge clk) disable iff (rst)
    dp_cmd.out_load |-> dp_sts.out_free)
    else $error("output element overwritten before it was taken");

  // operand reads and finished dot products only while a multiply runs
  assert property (@(posedge clk) disable iff (rst)
    (dp_cmd.ab_rd || dp_sts.acc_done) |-> !s_tready)
    else $error("mac activity while requests are accepted");

  // an output load follows a sequential c read or a cycle without a load
  assert property (@(posedge clk) disable iff (rst)
    dp_cmd.out_load |-> $past(dp_cmd.c_rd && dp_cmd.c_rd_seq) || $past(dp_cmd.out_load == 1'b0))
    else $error("output loaded without a preceding c read");

endmodule
`default_nettype wire
